// ===== hw/rtl/spqi_pkg.sv =====
package spqi_pkg;

    localparam int DEPTH_DEF = 16;

    typedef struct packed {
        logic [7:0]  prio_key;
        logic [15:0] arrival_stamp;
        logic [7:0]  payload_tag;
    } t_in_word;

    typedef struct packed {
        logic [7:0]  out_prio;
        logic [15:0] out_arrival;
        logic [7:0]  out_tag;
        logic [3:0]  position;
        logic        rejected;
        logic        last_of_run;
    } t_out_word;

    typedef struct packed {
        logic [7:0]  prio;
        logic [15:0] arrival;
        logic [7:0]  tag;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        logic load;
        logic rd;
        logic shift;
        logic place;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
        logic outranks;
        logic hole_one;
        logic emit_last;
    } t_sts;

endpackage

// ===== hw/rtl/spqi_ram.sv =====
module spqi_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/spqi_ctrl.sv =====
module spqi_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  spqi_pkg::t_sts  i_sts,
    output spqi_pkg::t_cmd  o_cmd,
    output logic            o_busy
);

    import spqi_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_RD    = 5'b00010,
        S_CMP   = 5'b00100,
        S_PLACE = 5'b01000,
        S_EMIT  = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;
    t_cmd   cmd;

    always_comb begin
        n_state = r_state;
        cmd     = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    cmd.load = 1'b1;
                    if (i_sts.full) begin
                        n_state = S_EMIT;
                    end else if (i_sts.empty) begin
                        n_state = S_PLACE;
                    end else begin
                        n_state = S_RD;
                    end
                end
            end
            S_RD: begin
                cmd.rd  = 1'b1;
                n_state = S_CMP;
            end
            S_CMP: begin
                if (i_sts.outranks) begin
                    cmd.shift = 1'b1;
                    n_state   = i_sts.hole_one ? S_PLACE : S_RD;
                end else begin
                    n_state = S_PLACE;
                end
            end
            S_PLACE: begin
                cmd.place = 1'b1;
                n_state   = S_EMIT;
            end
            S_EMIT: begin
                cmd.emit = 1'b1;
                if (i_sts.emit_last) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_cmd  = cmd;
    assign o_busy = (r_state != S_IDLE);

endmodule

// ===== hw/rtl/spqi_dp.sv =====
module spqi_dp #(
    parameter int DEPTH = spqi_pkg::DEPTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  spqi_pkg::t_in_word  i_word,
    input  spqi_pkg::t_cmd      i_cmd,
    output spqi_pkg::t_sts      o_sts,
    output logic                o_strobe,
    output spqi_pkg::t_out_word o_result
);

    import spqi_pkg::*;

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_in_word        r_new;
    logic [IW-1:0]   r_hole;
    logic [CW-1:0]   r_count;
    logic [IW-1:0]   r_ecnt;
    logic [3:0]      r_epos;
    logic            r_rej;
    logic            r_ostb;
    logic            r_olast;
    logic [3:0]      r_opos;
    logic            r_orej;

    logic            ram_we;
    logic [IW-1:0]   ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic            ram_re;
    logic [IW-1:0]   ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;
    t_entry          rd_entry;
    t_entry          new_entry;
    logic            emit_last;

    assign rd_entry  = t_entry'(ram_rdata);
    assign new_entry = '{prio: r_new.prio_key, arrival: r_new.arrival_stamp,
                         tag: r_new.payload_tag};

    assign ram_we    = i_cmd.shift | i_cmd.place;
    assign ram_waddr = r_hole;
    assign ram_wdata = i_cmd.shift ? ram_rdata : ENTRY_W'(new_entry);
    assign ram_re    = i_cmd.rd | i_cmd.emit;
    assign ram_raddr = i_cmd.emit ? r_ecnt : (r_hole - IW'(1));

    assign emit_last = ((CW'(r_ecnt) + CW'(1)) == r_count);

    spqi_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        o_sts.full      = (r_count == CW'(DEPTH));
        o_sts.empty     = (r_count == '0);
        o_sts.outranks  = (r_new.prio_key < rd_entry.prio) ||
                          ((r_new.prio_key == rd_entry.prio) &&
                           (r_new.arrival_stamp < rd_entry.arrival));
        o_sts.hole_one  = (r_hole == IW'(1));
        o_sts.emit_last = emit_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_ostb  <= 1'b0;
        end else begin
            if (i_cmd.place) begin
                r_count <= r_count + CW'(1);
            end
            r_ostb <= i_cmd.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_new  <= i_word;
            r_hole <= r_count[IW-1:0];
            r_rej  <= (r_count == CW'(DEPTH));
            r_ecnt <= '0;
            r_epos <= '0;
        end
        if (i_cmd.shift) begin
            r_hole <= r_hole - IW'(1);
        end
        if (i_cmd.emit) begin
            r_ecnt  <= r_ecnt + IW'(1);
            r_epos  <= r_epos + 4'd1;
            r_opos  <= r_epos;
            r_olast <= emit_last;
            r_orej  <= r_rej;
        end
    end

    assign o_strobe = r_ostb;

    always_comb begin
        o_result.out_prio    = rd_entry.prio;
        o_result.out_arrival = rd_entry.arrival;
        o_result.out_tag     = rd_entry.tag;
        o_result.position    = r_opos;
        o_result.rejected    = r_orej;
        o_result.last_of_run = r_olast;
    end

endmodule

// ===== hw/rtl/sorted_priority_queue_insert.sv =====
// Channel  | Ports                    | Handshake
// ---------+--------------------------+-------------------------------------
// input    | start, busy, i_word      | word taken when start && !busy
// result   | o_strobe, o_result       | word valid for the one o_strobe cycle
//
// An insert reads and compares stored entries from the back, moving each
// one down while the new entry outranks it, then places the new entry and
// reads out the whole queue; a word that arrives when the queue is full
// is rejected and only the readout runs.
// Each insert step is a registered RAM read and a compare, with
// a move where the new entry outranks, then one read per result.
// Reset is synchronous and empties the queue; no clearing pass is needed.
// Results stream one per cycle, front first; the receiver cannot stall.
module sorted_priority_queue_insert #(
    parameter int DEPTH = spqi_pkg::DEPTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  spqi_pkg::t_in_word  i_word,
    output logic                o_strobe,
    output spqi_pkg::t_out_word o_result
);

    import spqi_pkg::*;

    t_cmd cmd;
    t_sts sts;

    spqi_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    spqi_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_word   (i_word),
        .i_cmd    (cmd),
        .o_sts    (sts),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

endmodule

// ===== hw/rtl/spqi_checker.sv =====
module spqi_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                start,
    input logic                busy,
    input spqi_pkg::t_in_word  i_word,
    input logic                o_strobe,
    input spqi_pkg::t_out_word o_result
);

    import spqi_pkg::*;

    a_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after a word was taken");

    a_run_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_result.last_of_run) |=> o_strobe)
        else $error("gap inside a readout");

    a_run_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_result.last_of_run) |-> busy)
        else $error("idle with a readout still running");

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.last_of_run) |=> !o_strobe)
        else $error("result after the last word of a readout");

    a_pos_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && $past(o_strobe) && !$past(o_result.last_of_run)) |->
        ((o_result.position == ($past(o_result.position) + 4'd1)) &&
         (o_result.rejected == $past(o_result.rejected))))
        else $error("position or reject flag broken within a readout");

endmodule

bind sorted_priority_queue_insert spqi_checker u_spqi_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .i_word   (i_word),
    .o_strobe (o_strobe),
    .o_result (o_result)
);
